// ----- rtl/bcmc_pkg.sv -----
// Shared types, constants and helpers for the balance cascade motor controller.
`timescale 1ns / 1ps

package bcmc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPRIGHT_GAIN_D   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BALANCE_ANGLE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_P     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN_I     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_GAIN       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND_OFFSET = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE       = 3'd7;

	// Drive commands
	localparam logic [2:0] CMD_FORWARD = 3'd1;
	localparam logic [2:0] CMD_BACK    = 3'd2;
	localparam logic [2:0] CMD_LEFT    = 3'd3;
	localparam logic [2:0] CMD_RIGHT   = 3'd4;

	// Shared multiplier and accumulator widths
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 18;
	localparam int ACC_W   = MUL_A_W + MUL_B_W;

	// Fixed coefficients
	localparam logic signed [16:0] RATE_X_BIAS   = 17'sd62;
	localparam logic signed [MUL_B_W-1:0] SF_NEW_COEF  = 18'sd77;   // 0.3 in Q8
	localparam logic signed [MUL_B_W-1:0] SF_OLD_COEF  = 18'sd179;  // 0.7 in Q8
	localparam logic signed [MUL_B_W-1:0] RATE_Z_GAIN  = 18'sd7;
	localparam logic signed [19:0] MOVE_OFFSET   = 20'sd200;
	localparam logic signed [8:0]  STEER_STEP    = 9'sd70;
	localparam logic signed [8:0]  STEER_LIMIT   = 9'sd100;
	// Integer roll beyond 50 degrees: |roll| >= 51 * 256 in Q8.8
	localparam logic signed [16:0] TILT_LIMIT    = 17'sd13056;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_P,
		ST_UP_D,
		ST_SF_A,
		ST_SF_B,
		ST_SF_SUM,
		ST_SF_DIV,
		ST_INTEG,
		ST_SPD_I,
		ST_SPD_SUM,
		ST_SPD_DIV,
		ST_MIX
	} state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_UP_P,
		MUL_UP_D,
		MUL_SF_IN,
		MUL_SF_FB,
		MUL_STEER,
		MUL_RATE_Z,
		MUL_SPD_P,
		MUL_SPD_I
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD_SH4,
		ACC_LOAD_SH8,
		ACC_ADD,
		ACC_LOAD_NEG,
		ACC_ADD_DIV
	} acc_op_t;

	typedef struct packed {
		logic     in_ready;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     ld_target;
		logic     ld_upright;
		logic     ld_sf;
		logic     ld_turn;
		logic     ld_integral;
		logic     ld_speed;
		logic     ld_result;
	} ctrl_t;

	// Divide by 256, rounding toward zero
	function automatic logic signed [ACC_W-1:0] div256(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] bias;
		bias = x[ACC_W-1] ? ACC_W'(255) : '0;
		return (x + bias) >>> 8;
	endfunction

endpackage

// ----- rtl/bcmc_in_if.sv -----
// Input channel of the balance controller: one sensor tick per transfer.
`timescale 1ns / 1ps

interface bcmc_in_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] roll_angle;
	logic signed [15:0] rate_x;
	logic signed [15:0] rate_z;
	logic signed [15:0] left_count;
	logic signed [15:0] right_count;
	logic        [2:0]  drive_command;

	modport source (
		output valid, roll_angle, rate_x, rate_z, left_count, right_count, drive_command,
		input  ready
	);
	modport sink (
		input  valid, roll_angle, rate_x, rate_z, left_count, right_count, drive_command,
		output ready
	);
endinterface

// ----- rtl/bcmc_out_if.sv -----
// Output channel of the balance controller: one motor command per transfer.
`timescale 1ns / 1ps

interface bcmc_out_if;
	logic        valid;
	logic        ready;
	logic [13:0] left_duty;
	logic [13:0] right_duty;
	logic        left_forward;
	logic        right_forward;
	logic        tilted;
	logic        driving;

	modport source (
		output valid, left_duty, right_duty, left_forward, right_forward, tilted, driving,
		input  ready
	);
	modport sink (
		input  valid, left_duty, right_duty, left_forward, right_forward, tilted, driving,
		output ready
	);
endinterface

// ----- rtl/bcmc_mul.sv -----
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps

module bcmc_mul (
	input  logic                                  clk,
	input  logic signed [bcmc_pkg::MUL_A_W-1:0]   a_op,
	input  logic signed [bcmc_pkg::MUL_B_W-1:0]   b_op,
	output logic signed [bcmc_pkg::ACC_W-1:0]     prod_q
);
	import bcmc_pkg::*;

	logic signed [ACC_W-1:0] full;

	assign full = a_op * b_op;

	always_ff @(posedge clk) begin
		prod_q <= full;
	end
endmodule

// ----- rtl/bcmc_ctrl.sv -----
// Sequencer that steps the shared multiplier and accumulator through one tick.
`timescale 1ns / 1ps

module bcmc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_busy,
	output bcmc_pkg::ctrl_t ctrl
);
	import bcmc_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_UP_P;
			ST_UP_P:    state_d = ST_UP_D;
			ST_UP_D:    state_d = ST_SF_A;
			ST_SF_A:    state_d = ST_SF_B;
			ST_SF_B:    state_d = ST_SF_SUM;
			ST_SF_SUM:  state_d = ST_SF_DIV;
			ST_SF_DIV:  state_d = ST_INTEG;
			ST_INTEG:   state_d = ST_SPD_I;
			ST_SPD_I:   state_d = ST_SPD_SUM;
			ST_SPD_SUM: state_d = ST_SPD_DIV;
			ST_SPD_DIV: state_d = ST_MIX;
			ST_MIX:     if (!out_busy) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Most steps issue one product and consume the one issued by the step before.
	always_comb begin
		ctrl = '0;
		ctrl.mul_sel = MUL_NONE;
		ctrl.acc_op  = ACC_HOLD;
		case (state_q)
			ST_IDLE: begin
				ctrl.in_ready = 1'b1;
			end
			ST_UP_P: begin
				ctrl.mul_sel   = MUL_UP_P;
				ctrl.ld_target = 1'b1;
			end
			ST_UP_D: begin
				ctrl.mul_sel = MUL_UP_D;
				ctrl.acc_op  = ACC_LOAD;
			end
			ST_SF_A: begin
				ctrl.mul_sel = MUL_SF_IN;
				ctrl.acc_op  = ACC_ADD_SH4;
			end
			ST_SF_B: begin
				ctrl.mul_sel    = MUL_SF_FB;
				ctrl.acc_op     = ACC_LOAD_SH8;
				ctrl.ld_upright = 1'b1;
			end
			ST_SF_SUM: begin
				ctrl.mul_sel = MUL_STEER;
				ctrl.acc_op  = ACC_ADD;
			end
			ST_SF_DIV: begin
				ctrl.mul_sel = MUL_RATE_Z;
				ctrl.acc_op  = ACC_LOAD_NEG;
				ctrl.ld_sf   = 1'b1;
			end
			ST_INTEG: begin
				ctrl.mul_sel     = MUL_SPD_P;
				ctrl.ld_turn     = 1'b1;
				ctrl.ld_integral = 1'b1;
			end
			ST_SPD_I: begin
				ctrl.mul_sel = MUL_SPD_I;
				ctrl.acc_op  = ACC_LOAD;
			end
			ST_SPD_SUM: begin
				ctrl.acc_op = ACC_ADD_DIV;
			end
			ST_SPD_DIV: begin
				ctrl.ld_speed = 1'b1;
			end
			ST_MIX: begin
				ctrl.ld_result = !out_busy;
			end
			default: begin
				ctrl.in_ready = 1'b0;
			end
		endcase
	end
endmodule

// ----- rtl/balance_cascade_motor_controller.sv -----
// Top level of the two-wheel balance cascade motor controller.
// One input transfer per control tick carries roll angle (Q8.8 degrees), the x and z
// gyro rates, both encoder counts and the drive command; one output transfer per tick
// returns both PWM duties, the direction bits, the tilt flag and the driving flag. Each
// tick runs from input transfer to result as one accept step plus eleven sequencer steps,
// a sequence set by the single shared 32x18 multiplier and its product register,
// which serve all eight products of the upright PD, speed filter, speed PI and turn terms
// in turn. The input side is ready only while the sequencer is idle; a finished result
// sits in the output register, and the next tick can be accepted while it waits. If the
// previous result has still not been taken when the next one is done, the sequencer holds
// at its final step. Terms truncate toward zero; the mix is limited to +-DRIVE_LIMIT per
// wheel and the speed integral to +-INTEGRAL_LIMIT. Beyond +-50 degrees of integer roll,
// or with run_enable clear, both duties are zero and the direction bits keep their last
// values. Write configuration registers only while the block is idle.
`timescale 1ns / 1ps

module balance_cascade_motor_controller #(
	parameter int DRIVE_LIMIT    = 7000,
	parameter int INTEGRAL_LIMIT = 3000
) (
	input  logic                                clk,
	input  logic                                arst_n,
	bcmc_in_if.sink                             in_ch,
	bcmc_out_if.source                          out_ch,
	input  logic                                cfg_write_en,
	input  logic [bcmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bcmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bcmc_pkg::*;

	localparam logic signed [19:0] INT_LIM = 20'(INTEGRAL_LIMIT);
	localparam logic signed [33:0] MIX_LIM = 34'(DRIVE_LIMIT);

	// Configuration registers
	logic signed [11:0] gain_p_q;
	logic signed [10:0] gain_d_q;
	logic signed [12:0] balance_q;
	logic        [7:0]  speed_p_q;
	logic        [15:0] speed_i_q;
	logic        [7:0]  steer_gain_q;
	logic        [11:0] dead_band_q;
	logic               run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q     <= -12'sd550;
			gain_d_q     <= -11'sd32;
			balance_q    <= 13'sd64;
			speed_p_q    <= 8'd10;
			speed_i_q    <= 16'd3277;
			steer_gain_q <= 8'd10;
			dead_band_q  <= 12'd3000;
			run_q        <= 1'b0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				REG_UPRIGHT_GAIN_P:   gain_p_q     <= cfg_data[11:0];
				REG_UPRIGHT_GAIN_D:   gain_d_q     <= cfg_data[10:0];
				REG_BALANCE_ANGLE:    balance_q    <= cfg_data[12:0];
				REG_SPEED_GAIN_P:     speed_p_q    <= cfg_data[7:0];
				REG_SPEED_GAIN_I:     speed_i_q    <= cfg_data[15:0];
				REG_STEER_GAIN:       steer_gain_q <= cfg_data[7:0];
				REG_DEAD_BAND_OFFSET: dead_band_q  <= cfg_data[11:0];
				REG_RUN_ENABLE:       run_q        <= cfg_data[0];
				default:              run_q        <= run_q;
			endcase
		end
	end

	// Sequencer
	ctrl_t ctrl;
	logic  out_busy;

	assign out_busy    = out_ch.valid && !out_ch.ready;
	assign in_ch.ready = ctrl.in_ready;

	bcmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.out_busy (out_busy),
		.ctrl     (ctrl)
	);

	// Latch the tick's inputs on transfer; fold the two encoder counts at once.
	logic signed [16:0] roll_q;
	logic signed [15:0] rate_x_q;
	logic signed [15:0] rate_z_q;
	logic signed [16:0] count_sum_q;
	logic        [2:0]  cmd_q;

	always_ff @(posedge clk) begin
		if (ctrl.in_ready && in_ch.valid) begin
			roll_q      <= in_ch.roll_angle;
			rate_x_q    <= in_ch.rate_x;
			rate_z_q    <= in_ch.rate_z;
			count_sum_q <= 17'(in_ch.left_count) + 17'(in_ch.right_count);
			cmd_q       <= in_ch.drive_command;
		end
	end

	logic is_fwd;
	logic is_back;

	assign is_fwd  = (cmd_q == CMD_FORWARD);
	assign is_back = (cmd_q == CMD_BACK);

	// Controller state
	logic signed [31:0] sf_q;
	logic signed [15:0] integral_q;
	logic signed [7:0]  target_q;
	logic               left_hold_q;
	logic               right_hold_q;
	logic               tilted_last_q;

	// Shared multiplier operand select
	logic signed [17:0]        roll_err;
	logic signed [16:0]        rate_x_biased;
	logic signed [MUL_A_W-1:0] a_op;
	logic signed [MUL_B_W-1:0] b_op;
	logic signed [ACC_W-1:0]   prod_q;

	assign roll_err      = 18'(roll_q) - 18'(balance_q);
	assign rate_x_biased = 17'(rate_x_q) + RATE_X_BIAS;

	always_comb begin
		case (ctrl.mul_sel)
			MUL_UP_P: begin
				a_op = MUL_A_W'(roll_err);
				b_op = MUL_B_W'(gain_p_q);
			end
			MUL_UP_D: begin
				a_op = MUL_A_W'(rate_x_biased);
				b_op = MUL_B_W'(gain_d_q);
			end
			MUL_SF_IN: begin
				a_op = MUL_A_W'(count_sum_q);
				b_op = SF_NEW_COEF;
			end
			MUL_SF_FB: begin
				a_op = sf_q;
				b_op = SF_OLD_COEF;
			end
			MUL_STEER: begin
				a_op = MUL_A_W'(target_q);
				b_op = $signed({10'd0, steer_gain_q});
			end
			MUL_RATE_Z: begin
				a_op = MUL_A_W'(rate_z_q);
				b_op = (is_fwd || is_back) ? RATE_Z_GAIN : '0;
			end
			MUL_SPD_P: begin
				a_op = sf_q;
				b_op = $signed({10'd0, speed_p_q});
			end
			MUL_SPD_I: begin
				a_op = MUL_A_W'(integral_q);
				b_op = $signed({2'd0, speed_i_q});
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	bcmc_mul u_mul (
		.clk    (clk),
		.a_op   (a_op),
		.b_op   (b_op),
		.prod_q (prod_q)
	);

	// Accumulator: combine the registered product into the running sum.
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] acc_d;
	logic signed [ACC_W-1:0] acc_sum;
	logic signed [ACC_W-1:0] acc_div;

	assign acc_sum = acc_q + prod_q;
	assign acc_div = div256(acc_q);

	always_comb begin
		case (ctrl.acc_op)
			ACC_LOAD:     acc_d = prod_q;
			ACC_ADD_SH4:  acc_d = acc_q + (prod_q <<< 4);
			ACC_LOAD_SH8: acc_d = prod_q <<< 8;
			ACC_ADD:      acc_d = acc_sum;
			ACC_LOAD_NEG: acc_d = -prod_q;
			ACC_ADD_DIV:  acc_d = acc_q + div256(prod_q);
			default:      acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_d;
	end

	// Term registers
	logic signed [31:0] upright_q;
	logic signed [31:0] turn_q;
	logic signed [31:0] speed_q;

	always_ff @(posedge clk) begin
		if (ctrl.ld_upright) begin
			upright_q <= acc_div[31:0];
		end
		if (ctrl.ld_turn) begin
			turn_q <= acc_sum[31:0];
		end
		if (ctrl.ld_speed) begin
			speed_q <= acc_div[31:0];
		end
	end

	// Steering target ramp: step on left/right, drop to zero otherwise.
	logic signed [8:0] target_step;
	logic signed [7:0] target_next;

	always_comb begin
		case (cmd_q)
			CMD_LEFT:  target_step = 9'(target_q) + STEER_STEP;
			CMD_RIGHT: target_step = 9'(target_q) - STEER_STEP;
			default:   target_step = '0;
		endcase
		if (target_step > STEER_LIMIT) begin
			target_next = STEER_LIMIT[7:0];
		end else if (target_step < -STEER_LIMIT) begin
			target_next = 8'(-STEER_LIMIT);
		end else begin
			target_next = target_step[7:0];
		end
	end

	// Speed integral: add the filtered speed in whole counts, offset by the command,
	// clamp, and clear after a tilt on the previous tick or while not running.
	logic signed [ACC_W-1:0] sf_wide;
	logic signed [ACC_W-1:0] sf_whole;
	logic signed [19:0]      move;
	logic signed [19:0]      integral_sum;
	logic signed [19:0]      integral_clamped;
	logic signed [15:0]      integral_next;

	assign sf_wide  = ACC_W'(sf_q);
	assign sf_whole = div256(sf_wide);

	always_comb begin
		if (is_fwd) begin
			move = -MOVE_OFFSET;
		end else if (is_back) begin
			move = MOVE_OFFSET;
		end else begin
			move = '0;
		end
		integral_sum = 20'(integral_q) + sf_whole[19:0] - move;
		if (integral_sum > INT_LIM) begin
			integral_clamped = INT_LIM;
		end else if (integral_sum < -INT_LIM) begin
			integral_clamped = -INT_LIM;
		end else begin
			integral_clamped = integral_sum;
		end
		if (tilted_last_q || !run_q) begin
			integral_next = '0;
		end else begin
			integral_next = integral_clamped[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q       <= '0;
			integral_q <= '0;
			target_q   <= '0;
		end else begin
			if (ctrl.ld_sf) begin
				sf_q <= acc_div[31:0];
			end
			if (ctrl.ld_integral) begin
				integral_q <= integral_next;
			end
			if (ctrl.ld_target) begin
				target_q <= target_next;
			end
		end
	end

	// Mix, limit, and form duties with dead-band offset.
	logic signed [33:0] base_sum;
	logic signed [33:0] mix_l;
	logic signed [33:0] mix_r;
	logic signed [15:0] lim_l;
	logic signed [15:0] lim_r;
	logic        [15:0] mag_l;
	logic        [15:0] mag_r;
	logic        [16:0] duty_l;
	logic        [16:0] duty_r;
	logic               tilted;
	logic               drive_now;
	logic               left_hold_next;
	logic               right_hold_next;

	assign base_sum = 34'(upright_q) + 34'(speed_q);
	assign mix_l    = base_sum + 34'(turn_q);
	assign mix_r    = base_sum - 34'(turn_q);

	always_comb begin
		if (mix_l > MIX_LIM) begin
			lim_l = MIX_LIM[15:0];
		end else if (mix_l < -MIX_LIM) begin
			lim_l = 16'(-MIX_LIM);
		end else begin
			lim_l = mix_l[15:0];
		end
		if (mix_r > MIX_LIM) begin
			lim_r = MIX_LIM[15:0];
		end else if (mix_r < -MIX_LIM) begin
			lim_r = 16'(-MIX_LIM);
		end else begin
			lim_r = mix_r[15:0];
		end
	end

	assign mag_l  = lim_l[15] ? 16'(-lim_l) : 16'(lim_l);
	assign mag_r  = lim_r[15] ? 16'(-lim_r) : 16'(lim_r);
	assign duty_l = 17'(mag_l) + 17'(dead_band_q);
	assign duty_r = 17'(mag_r) + 17'(dead_band_q);

	// Tilt check on integer roll, evaluated every tick.
	assign tilted    = (roll_q >= TILT_LIMIT) || (roll_q <= -TILT_LIMIT);
	assign drive_now = run_q && !tilted;

	assign left_hold_next  = drive_now ? (lim_l > 16'sd0) : left_hold_q;
	assign right_hold_next = drive_now ? (lim_r > 16'sd0) : right_hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_hold_q   <= 1'b0;
			right_hold_q  <= 1'b0;
			tilted_last_q <= 1'b0;
		end else if (ctrl.ld_result) begin
			left_hold_q   <= left_hold_next;
			right_hold_q  <= right_hold_next;
			tilted_last_q <= tilted;
		end
	end

	// Output register: hold the result until the sink takes it.
	logic        out_valid_q;
	logic [13:0] left_duty_q;
	logic [13:0] right_duty_q;
	logic        left_fwd_q;
	logic        right_fwd_q;
	logic        tilted_q;
	logic        driving_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.ld_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ld_result) begin
			left_duty_q  <= drive_now ? duty_l[13:0] : '0;
			right_duty_q <= drive_now ? duty_r[13:0] : '0;
			left_fwd_q   <= left_hold_next;
			right_fwd_q  <= right_hold_next;
			tilted_q     <= tilted;
			driving_q    <= run_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.left_duty     = left_duty_q;
	assign out_ch.right_duty    = right_duty_q;
	assign out_ch.left_forward  = left_fwd_q;
	assign out_ch.right_forward = right_fwd_q;
	assign out_ch.tilted        = tilted_q;
	assign out_ch.driving       = driving_q;

	// A transfer starts the sequencer, so the input side must drop ready at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input still ready after a transfer");

	// Tilted or stopped results never carry a duty.
	a_zero_duty_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.tilted || !out_ch.driving)) |->
		(out_ch.left_duty == '0 && out_ch.right_duty == '0))
		else $error("nonzero duty while tilted or not driving");

	// The speed integral stays within its clamp.
	a_integral_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(20'(integral_q) <= INT_LIM) && (20'(integral_q) >= -INT_LIM))
		else $error("speed integral outside its limit");

	// The steering target stays within its ramp limit.
	a_target_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(9'(target_q) <= STEER_LIMIT) && (9'(target_q) >= -STEER_LIMIT))
		else $error("steering target outside its limit");
endmodule

// ----- verif/tb_balance_cascade_motor_controller.sv -----
// Self-checking testbench for the balance cascade motor controller: directed ticks, then random phases.
`timescale 1ns / 1ps

module tb_balance_cascade_motor_controller;
	import bcmc_pkg::*;

	localparam int DRIVE_LIMIT    = 7000;
	localparam int INTEGRAL_LIMIT = 3000;

	// Fixed terms of the control law
	localparam longint Q8_ONE        = 256;
	localparam longint RATE_X_OFFSET = 62;
	localparam longint SF_NEW_Q8     = 77;   // 0.3 of the new wheel speed
	localparam longint SF_OLD_Q8     = 179;  // 0.7 of the filtered speed
	localparam longint MOVE_STEP     = 200;
	localparam longint STEER_RAMP    = 70;
	localparam longint STEER_MAX     = 100;
	localparam longint RATE_Z_KD     = 7;
	localparam longint TILT_DEG      = 50;

	// Stop codes: zero and the commands that are not listed
	localparam logic [2:0] CMD_STOP   = 3'd0;
	localparam logic [2:0] CMD_SPARE5 = 3'd5;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	localparam int RESULT_LATENCY  = 16;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 8;
	localparam int TICKS_PER_PHASE = 100;
	localparam int MAX_REPORTS     = 100;

	typedef struct packed {
		logic signed [16:0] roll;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_z;
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic        [2:0]  cmd;
	} tick_t;

	typedef struct packed {
		logic [13:0] left_duty;
		logic [13:0] right_duty;
		logic        left_fwd;
		logic        right_fwd;
		logic        tilted;
		logic        driving;
	} motor_cmd_t;

	typedef enum logic [1:0] {
		RUN_KEEP,
		RUN_OFF,
		RUN_ON
	} run_switch_t;

	typedef struct packed {
		run_switch_t run_switch;
		tick_t       tick;
		logic        typed;
		motor_cmd_t  want;
	} tick_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	bcmc_in_if  in_ch ();
	bcmc_out_if out_ch ();

	balance_cascade_motor_controller #(
		.DRIVE_LIMIT    (DRIVE_LIMIT),
		.INTEGRAL_LIMIT (INTEGRAL_LIMIT)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.out_ch       (out_ch),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Motor commands still owed by the block, oldest first
	motor_cmd_t motor_cmd_due[$];
	tick_row_t  tick_table[$];
	int         mismatch_count;
	int         results_seen;
	bit         no_gaps;

	// Register copy, kept at the register widths
	logic signed [11:0] up_gain_p;
	logic signed [10:0] up_gain_d;
	logic signed [12:0] bal_angle;
	logic        [7:0]  spd_gain_p;
	logic        [15:0] spd_gain_i;
	logic        [7:0]  turn_gain;
	logic        [11:0] dz_offset;
	logic               run_en;

	// Controller state carried from tick to tick
	longint sf_q8;
	longint spd_integ;
	longint steer_tgt;
	logic   hold_left_fwd;
	logic   hold_right_fwd;
	logic   tilt_prev;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clamp_sym(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// Most gaps are zero or short, a few are long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the controller state by one tick and return the motor command it yields.
	function automatic motor_cmd_t predict_motor_cmd(input tick_t t);
		longint roll, rx, rz, lc, rc;
		longint upright, move, speed, kd, turn, ml, mr, deg, dl, dr;
		logic tilt;
		motor_cmd_t r;
		roll = signed'(t.roll);
		rx   = signed'(t.rate_x);
		rz   = signed'(t.rate_z);
		lc   = signed'(t.left_count);
		rc   = signed'(t.right_count);

		// Upright PD on the roll offset and the biased x rate
		upright = (longint'(up_gain_p) * (roll - longint'(bal_angle)) +
			longint'(up_gain_d) * 16 * (rx + RATE_X_OFFSET)) / Q8_ONE;

		if (t.cmd == CMD_FORWARD)
			move = -MOVE_STEP;
		else if (t.cmd == CMD_BACK)
			move = MOVE_STEP;
		else
			move = 0;

		// Speed PI: low-pass the wheel sum, integrate, clear after a tilt or while stopped
		sf_q8 = (SF_NEW_Q8 * ((lc + rc) * Q8_ONE) + SF_OLD_Q8 * sf_q8) / Q8_ONE;
		spd_integ = clamp_sym(spd_integ + sf_q8 / Q8_ONE - move, INTEGRAL_LIMIT);
		if (tilt_prev || !run_en)
			spd_integ = 0;
		speed = (longint'(spd_gain_p) * sf_q8 +
			(longint'(spd_gain_i) * spd_integ) / Q8_ONE) / Q8_ONE;

		// Turn: ramp the target while left or right is held, drop it otherwise
		case (t.cmd)
			CMD_LEFT:  steer_tgt = clamp_sym(steer_tgt + STEER_RAMP, STEER_MAX);
			CMD_RIGHT: steer_tgt = clamp_sym(steer_tgt - STEER_RAMP, STEER_MAX);
			default:   steer_tgt = 0;
		endcase
		kd = (t.cmd == CMD_FORWARD || t.cmd == CMD_BACK) ? RATE_Z_KD : 0;
		turn = -steer_tgt * longint'(turn_gain) + rz * kd;

		ml = clamp_sym(upright + speed + turn, DRIVE_LIMIT);
		mr = clamp_sym(upright + speed - turn, DRIVE_LIMIT);

		deg = roll / Q8_ONE;
		tilt = (deg < -TILT_DEG || deg > TILT_DEG);
		tilt_prev = tilt;

		dl = 0;
		dr = 0;
		if (run_en && !tilt) begin
			hold_left_fwd  = (ml > 0);
			hold_right_fwd = (mr > 0);
			dl = (ml < 0 ? -ml : ml) + longint'(dz_offset);
			dr = (mr < 0 ? -mr : mr) + longint'(dz_offset);
		end

		r.left_duty  = dl[13:0];
		r.right_duty = dr[13:0];
		r.left_fwd   = hold_left_fwd;
		r.right_fwd  = hold_right_fwd;
		r.tilted     = tilt;
		r.driving    = run_en;
		return r;
	endfunction

	// Typed rows always come with zero duties and cleared direction bits; only tilt varies.
	function automatic void add_row(input run_switch_t sw, input int roll, input int rx,
			input int rz, input int lc, input int rc, input logic [2:0] cmd,
			input logic typed, input logic want_tilt);
		tick_row_t row;
		row.run_switch       = sw;
		row.tick.roll        = 17'(roll);
		row.tick.rate_x      = 16'(rx);
		row.tick.rate_z      = 16'(rz);
		row.tick.left_count  = 16'(lc);
		row.tick.right_count = 16'(rc);
		row.tick.cmd         = cmd;
		row.typed            = typed;
		row.want             = '0;
		row.want.tilted      = want_tilt;
		tick_table.push_back(row);
	endfunction

	task automatic flag_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		if (mismatch_count < MAX_REPORTS)
			$display("%0t ns: result %0d %s: got %0d, expected %0d",
				$time, results_seen, what, got, want);
		mismatch_count++;
	endtask

	// Write one register and mirror it; the caller drops the write enable afterwards.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		case (idx)
			REG_UPRIGHT_GAIN_P:   up_gain_p  = value[11:0];
			REG_UPRIGHT_GAIN_D:   up_gain_d  = value[10:0];
			REG_BALANCE_ANGLE:    bal_angle  = value[12:0];
			REG_SPEED_GAIN_P:     spd_gain_p = value[7:0];
			REG_SPEED_GAIN_I:     spd_gain_i = value[15:0];
			REG_STEER_GAIN:       turn_gain  = value[7:0];
			REG_DEAD_BAND_OFFSET: dz_offset  = value[11:0];
			REG_RUN_ENABLE:       run_en     = value[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Hold the sender off until every owed motor command has been taken.
	task automatic wait_all_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (motor_cmd_due.size() != 0)
			@(posedge clk);
	endtask

	// Idle for a random gap, offer the tick until it transfers, then book its motor command.
	task automatic issue_tick(input tick_t t, input logic typed, input motor_cmd_t want);
		int gap;
		motor_cmd_t predicted;
		gap = no_gaps ? 0 : pick_gap();
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid         <= 1'b1;
		in_ch.roll_angle    <= t.roll;
		in_ch.rate_x        <= t.rate_x;
		in_ch.rate_z        <= t.rate_z;
		in_ch.left_count    <= t.left_count;
		in_ch.right_count   <= t.right_count;
		in_ch.drive_command <= t.cmd;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		predicted = predict_motor_cmd(t);
		motor_cmd_due.push_back(typed ? want : predicted);
	endtask

	// Output side: check every transfer against the oldest owed command, then drive
	// ready for the next edge, with random stalls unless gaps are off.
	initial begin
		int stall_left;
		motor_cmd_t got, want;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.left_duty  = out_ch.left_duty;
				got.right_duty = out_ch.right_duty;
				got.left_fwd   = out_ch.left_forward;
				got.right_fwd  = out_ch.right_forward;
				got.tilted     = out_ch.tilted;
				got.driving    = out_ch.driving;
				if (motor_cmd_due.size() == 0) begin
					flag_mismatch("result with no tick pending", 16'(got.left_duty), '0);
				end else begin
					want = motor_cmd_due.pop_front();
					if (got.left_duty !== want.left_duty)
						flag_mismatch("left_duty", 16'(got.left_duty),
							16'(want.left_duty));
					if (got.right_duty !== want.right_duty)
						flag_mismatch("right_duty", 16'(got.right_duty),
							16'(want.right_duty));
					if (got.left_fwd !== want.left_fwd)
						flag_mismatch("left_forward", 16'(got.left_fwd),
							16'(want.left_fwd));
					if (got.right_fwd !== want.right_fwd)
						flag_mismatch("right_forward", 16'(got.right_fwd),
							16'(want.right_fwd));
					if (got.tilted !== want.tilted)
						flag_mismatch("tilted", 16'(got.tilted), 16'(want.tilted));
					if (got.driving !== want.driving)
						flag_mismatch("driving", 16'(got.driving), 16'(want.driving));
				end
				results_seen++;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!no_gaps && $urandom_range(0, 2) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// Watchdog: end the run once no transfer has happened on either side for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		tick_row_t row;
		tick_t t;
		logic [CFG_DATA_W-1:0] setting [8];
		logic [2:0] prev_cmd;
		int base;

		// Hold every block input at a known value from time zero.
		arst_n              <= 1'b0;
		cfg_write_en        <= 1'b0;
		cfg_index           <= '0;
		cfg_data            <= '0;
		in_ch.valid         <= 1'b0;
		in_ch.roll_angle    <= '0;
		in_ch.rate_x        <= '0;
		in_ch.rate_z        <= '0;
		in_ch.left_count    <= '0;
		in_ch.right_count   <= '0;
		in_ch.drive_command <= CMD_STOP;

		// Register and state values after reset
		up_gain_p      = -12'sd550;
		up_gain_d      = -11'sd32;
		bal_angle      = 13'sd64;
		spd_gain_p     = 8'd10;
		spd_gain_i     = 16'd3277;
		turn_gain      = 8'd10;
		dz_offset      = 12'd3000;
		run_en         = 1'b0;
		sf_q8          = 0;
		spd_integ      = 0;
		steer_tgt      = 0;
		hold_left_fwd  = 1'b0;
		hold_right_fwd = 1'b0;
		tilt_prev      = 1'b0;
		mismatch_count = 0;
		results_seen   = 0;
		no_gaps        = 1'b0;
		prev_cmd       = CMD_STOP;

		// Directed ticks. While stopped from reset, duties and direction bits read zero,
		// so those rows carry their expected tilt flag; the rest are worked out tick by tick.
		//       switch    roll    rate_x  rate_z  left    right   command      typed tilt
		add_row(RUN_KEEP, 0,      0,      0,      0,      0,      CMD_STOP,    1'b1, 1'b0);
		add_row(RUN_KEEP, 46080,  32767,  -32768, 32767,  32767,  CMD_FORWARD, 1'b1, 1'b1);
		add_row(RUN_KEEP, -46080, -32768, 32767,  -32768, -32768, CMD_BACK,    1'b1, 1'b1);
		// Integer roll of exactly 50 degrees is still upright, 51 is tilted
		add_row(RUN_KEEP, 13055,  0,      0,      0,      0,      CMD_LEFT,    1'b1, 1'b0);
		add_row(RUN_KEEP, 13056,  0,      0,      0,      0,      CMD_RIGHT,   1'b1, 1'b1);
		add_row(RUN_KEEP, -13055, 0,      0,      0,      0,      CMD_SPARE5,  1'b1, 1'b0);
		add_row(RUN_KEEP, -13056, 0,      0,      0,      0,      CMD_SPARE7,  1'b1, 1'b1);
		// Start driving; the integral restarts since the last tick was tilted
		add_row(RUN_ON,   0,      0,      0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		add_row(RUN_KEEP, 64,     -62,    0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		add_row(RUN_KEEP, 2560,   500,    1000,   100,    120,    CMD_FORWARD, 1'b0, 1'b0);
		add_row(RUN_KEEP, 0,      0,      300,    -40,    -40,    CMD_BACK,    1'b0, 1'b0);
		// Ramp the steering target into its limit both ways
		add_row(RUN_KEEP, 256,    0,      200,    10,     10,     CMD_LEFT,    1'b0, 1'b0);
		add_row(RUN_KEEP, 256,    0,      200,    10,     10,     CMD_LEFT,    1'b0, 1'b0);
		add_row(RUN_KEEP, 256,    0,      200,    10,     10,     CMD_LEFT,    1'b0, 1'b0);
		add_row(RUN_KEEP, -256,   0,      -200,   -10,    -10,    CMD_RIGHT,   1'b0, 1'b0);
		add_row(RUN_KEEP, -256,   0,      -200,   -10,    -10,    CMD_RIGHT,   1'b0, 1'b0);
		add_row(RUN_KEEP, -256,   0,      -200,   -10,    -10,    CMD_RIGHT,   1'b0, 1'b0);
		// Saturate the mix in both directions
		add_row(RUN_KEEP, -12800, 32767,  0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		add_row(RUN_KEEP, 12800,  -32768, 0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		// Drive the integral into its clamp with extreme wheel counts
		add_row(RUN_KEEP, 0,      0,      32767,  32767,  32767,  CMD_BACK,    1'b0, 1'b0);
		add_row(RUN_KEEP, 0,      0,      -32768, -32768, -32768, CMD_FORWARD, 1'b0, 1'b0);
		// Tilted while driving keeps the direction bits; the next tick clears the integral
		add_row(RUN_KEEP, 46080,  0,      0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		add_row(RUN_KEEP, 0,      0,      0,      0,      0,      CMD_STOP,    1'b0, 1'b0);
		add_row(RUN_OFF,  100,    0,      0,      0,      0,      CMD_STOP,    1'b0, 1'b0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the table; switch run_enable only once the block has gone idle.
		foreach (tick_table[i]) begin
			row = tick_table[i];
			if (row.run_switch != RUN_KEEP) begin
				wait_all_results();
				write_reg(REG_RUN_ENABLE, (row.run_switch == RUN_ON) ? 16'd1 : 16'd0);
				cfg_write_en <= 1'b0;
			end
			issue_tick(row.tick, row.typed, row.want);
		end

		// Random phases, each under its own register setting.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_all_results();
			case (phase)
				0: begin
					// Bottom of every register range but the balance angle and run enable
					setting[REG_UPRIGHT_GAIN_P]   = 16'(-2048);
					setting[REG_UPRIGHT_GAIN_D]   = 16'(-1024);
					setting[REG_BALANCE_ANGLE]    = 16'(-2560);
					setting[REG_SPEED_GAIN_P]     = 16'd0;
					setting[REG_SPEED_GAIN_I]     = 16'd0;
					setting[REG_STEER_GAIN]       = 16'd0;
					setting[REG_DEAD_BAND_OFFSET] = 16'd0;
					setting[REG_RUN_ENABLE]       = 16'd1;
				end
				1: begin
					// Top of every register range but the balance angle; full dead band reaches the widest duty
					setting[REG_UPRIGHT_GAIN_P]   = 16'd2047;
					setting[REG_UPRIGHT_GAIN_D]   = 16'd1023;
					setting[REG_BALANCE_ANGLE]    = 16'd2560;
					setting[REG_SPEED_GAIN_P]     = 16'd255;
					setting[REG_SPEED_GAIN_I]     = 16'd65535;
					setting[REG_STEER_GAIN]       = 16'd255;
					setting[REG_DEAD_BAND_OFFSET] = 16'd4095;
					setting[REG_RUN_ENABLE]       = 16'd1;
				end
				2: begin
					// Stock tuning
					setting[REG_UPRIGHT_GAIN_P]   = 16'(-550);
					setting[REG_UPRIGHT_GAIN_D]   = 16'(-32);
					setting[REG_BALANCE_ANGLE]    = 16'd64;
					setting[REG_SPEED_GAIN_P]     = 16'd10;
					setting[REG_SPEED_GAIN_I]     = 16'd3277;
					setting[REG_STEER_GAIN]       = 16'd10;
					setting[REG_DEAD_BAND_OFFSET] = 16'd3000;
					setting[REG_RUN_ENABLE]       = 16'd1;
				end
				4, 6: begin
					// Near the stock tuning, so the loop spends time out of saturation
					setting[REG_UPRIGHT_GAIN_P]   = 16'($urandom_range(0, 512) - 806);
					setting[REG_UPRIGHT_GAIN_D]   = 16'($urandom_range(0, 64) - 64);
					setting[REG_BALANCE_ANGLE]    = 16'($urandom_range(0, 600) - 300);
					setting[REG_SPEED_GAIN_P]     = 16'($urandom_range(0, 30));
					setting[REG_SPEED_GAIN_I]     = 16'($urandom_range(0, 8000));
					setting[REG_STEER_GAIN]       = 16'($urandom_range(0, 30));
					setting[REG_DEAD_BAND_OFFSET] = 16'($urandom_range(0, 4095));
					setting[REG_RUN_ENABLE]       = 16'd1;
				end
				default: begin
					// Anything goes, junk in the bits above each register's width too
					foreach (setting[k])
						setting[k] = 16'($urandom());
					setting[REG_BALANCE_ANGLE] = {3'($urandom_range(0, 7)),
						13'($urandom_range(0, 5120) - 2560)};
					setting[REG_RUN_ENABLE] = {15'($urandom()), (phase != 3)};
				end
			endcase
			for (int k = 0; k < 8; k++)
				write_reg(CFG_IDX_W'(k), setting[k]);
			cfg_write_en <= 1'b0;

			// Run one phase back to back on both sides.
			no_gaps = (phase == 2);

			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if ($urandom_range(0, 9) < 7) begin
					// Plausible motion: moderate roll, rates and matched wheel counts
					t.roll   = 17'($urandom_range(0, 28000) - 14000);
					t.rate_x = 16'($urandom_range(0, 6000) - 3000);
					t.rate_z = 16'($urandom_range(0, 6000) - 3000);
					base     = $urandom_range(0, 400) - 200;
					t.left_count  = 16'(base + $urandom_range(0, 20) - 10);
					t.right_count = 16'(base + $urandom_range(0, 20) - 10);
				end else begin
					t.roll        = 17'($urandom_range(0, 92160) - 46080);
					t.rate_x      = 16'($urandom());
					t.rate_z      = 16'($urandom());
					t.left_count  = 16'($urandom());
					t.right_count = 16'($urandom());
				end
				// Hold a command for a while so steering ramps and drive offsets build up
				t.cmd = ($urandom_range(0, 9) < 7) ? prev_cmd : 3'($urandom_range(0, 7));
				prev_cmd = t.cmd;
				issue_tick(t, 1'b0, '0);
			end
		end

		wait_all_results();
		repeat (RESULT_LATENCY) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
